FILE: rtl/hjbq_pkg.sv
// shared types, register codes, reset values and the timer length helper
package hjbq_pkg;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CFG_BITS      = 16;

   typedef enum logic [2:0] {
      REG_JACK_SETTLE_ABSENT  = 3'd0,
      REG_JACK_SETTLE_PRESENT = 3'd1,
      REG_PRESS_SETTLE        = 3'd2,
      REG_PRESS_SETTLE_CALL   = 3'd3,
      REG_RELEASE_SETTLE      = 3'd4
   } reg_index_type;

   localparam logic [CFG_BITS-1:0] RST_JACK_SETTLE_ABSENT  = 16'd200;
   localparam logic [CFG_BITS-1:0] RST_JACK_SETTLE_PRESENT = 16'd20;
   localparam logic [CFG_BITS-1:0] RST_PRESS_SETTLE        = 16'd130;
   localparam logic [CFG_BITS-1:0] RST_PRESS_SETTLE_CALL   = 16'd400;
   localparam logic [CFG_BITS-1:0] RST_RELEASE_SETTLE      = 16'd10;

   typedef struct packed {
      logic [CFG_BITS-1:0] jack_settle_absent;
      logic [CFG_BITS-1:0] jack_settle_present;
      logic [CFG_BITS-1:0] press_settle;
      logic [CFG_BITS-1:0] press_settle_call;
      logic [CFG_BITS-1:0] release_settle;
   } cfg_type;

   // outcome of the jack qualifier for one tick, consumed by the button side
   typedef struct packed {
      logic present;
      logic inserted;
      logic removed;
      logic set_ignore;
   } jack_evt_type;

   // zero reads as one, values beyond the timer width saturate
   function automatic logic [31:0] timer_length(input logic [CFG_BITS-1:0] value,
                                                input int unsigned tb);
      logic [32:0] wide;
      logic [32:0] top;
      wide = 33'(value);
      top  = (33'd1 << tb) - 33'd1;
      if (wide == 33'd0) begin
         wide = 33'd1;
      end
      if (wide > top) begin
         wide = top;
      end
      return wide[31:0];
   endfunction

endpackage

FILE: rtl/hjbq_csr.sv
// configuration register file behind the apb-style port
module hjbq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hjbq_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hjbq_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hjbq_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output hjbq_pkg::cfg_type                   cfg
);
   import hjbq_pkg::*;

   cfg_type             cfg_ff;
   logic                wr_en;
   logic [2:0]          idx;
   logic [CFG_BITS-1:0] wdata;
   logic [CFG_BITS-1:0] rdata;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = csr_paddr[4:2];
   assign wdata = csr_pwdata[CFG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jack_settle_absent  <= RST_JACK_SETTLE_ABSENT;
         cfg_ff.jack_settle_present <= RST_JACK_SETTLE_PRESENT;
         cfg_ff.press_settle        <= RST_PRESS_SETTLE;
         cfg_ff.press_settle_call   <= RST_PRESS_SETTLE_CALL;
         cfg_ff.release_settle      <= RST_RELEASE_SETTLE;
      end else if (wr_en) begin
         case (idx)
            REG_JACK_SETTLE_ABSENT:  cfg_ff.jack_settle_absent  <= wdata;
            REG_JACK_SETTLE_PRESENT: cfg_ff.jack_settle_present <= wdata;
            REG_PRESS_SETTLE:        cfg_ff.press_settle        <= wdata;
            REG_PRESS_SETTLE_CALL:   cfg_ff.press_settle_call   <= wdata;
            REG_RELEASE_SETTLE:      cfg_ff.release_settle      <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_JACK_SETTLE_ABSENT:  rdata = cfg_ff.jack_settle_absent;
         REG_JACK_SETTLE_PRESENT: rdata = cfg_ff.jack_settle_present;
         REG_PRESS_SETTLE:        rdata = cfg_ff.press_settle;
         REG_PRESS_SETTLE_CALL:   rdata = cfg_ff.press_settle_call;
         REG_RELEASE_SETTLE:      rdata = cfg_ff.release_settle;
         default:                 rdata = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_BITS'(rdata);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

FILE: rtl/hjbq_jack.sv
// jack presence qualifier: settle timer and insert/remove decision
module hjbq_jack #(
   parameter int TIMER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   jack_level,
   input  hjbq_pkg::cfg_type      cfg,
   output hjbq_pkg::jack_evt_type jack_evt
);
   import hjbq_pkg::*;

   logic                  present_ff, present_in;
   logic                  jack_last_ff;
   logic                  running_ff, running_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [TIMER_BITS-1:0] len;
   logic [TIMER_BITS-1:0] dec;
   logic                  disagree;
   logic                  expire;

   assign disagree = (jack_level != jack_last_ff) && (jack_level != present_ff);
   assign len = TIMER_BITS'(timer_length(present_ff ? cfg.jack_settle_present
                                                    : cfg.jack_settle_absent, TIMER_BITS));
   assign dec = timer_ff - TIMER_BITS'(timer_ff != '0);

   always_comb begin
      timer_in   = timer_ff;
      running_in = running_ff;
      expire     = 1'b0;
      if (disagree) begin
         timer_in   = len;
         running_in = 1'b1;
      end else if (running_ff) begin
         timer_in = dec;
         if (dec == '0) begin
            running_in = 1'b0;
            expire     = 1'b1;
         end
      end
   end

   assign jack_evt.inserted   = expire && jack_level && !present_ff;
   assign jack_evt.removed    = expire && !jack_level && present_ff;
   assign jack_evt.set_ignore = disagree && present_ff;
   assign present_in          = jack_evt.inserted ? 1'b1 :
                                jack_evt.removed  ? 1'b0 : present_ff;
   assign jack_evt.present    = present_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         jack_last_ff <= 1'b0;
         running_ff   <= 1'b0;
         timer_ff     <= '0;
      end else if (step_en) begin
         present_ff   <= present_in;
         jack_last_ff <= jack_level;
         running_ff   <= running_in;
         timer_ff     <= timer_in;
      end
   end

   // a running settle timer never sits at zero
   a_timer_nonzero: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> timer_ff != '0)
      else $error("jack timer running at zero");

   // insertion and removal never fall on one tick
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      !(jack_evt.inserted && jack_evt.removed))
      else $error("jack inserted and removed together");

   // a restart leaves the timer running on the next edge
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && disagree |=> running_ff)
      else $error("jack timer not running after restart");

endmodule

FILE: rtl/hjbq_button.sv
// button qualifier: press/release settle timer, ignore flag and held state
module hjbq_button #(
   parameter int TIMER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   button_level,
   input  logic                   in_call,
   input  hjbq_pkg::cfg_type      cfg,
   input  hjbq_pkg::jack_evt_type jack_evt,
   output logic                   held,
   output logic                   pressed,
   output logic                   released
);
   import hjbq_pkg::*;

   logic                  held_ff, held_in;
   logic                  ignore_ff, ignore_in;
   logic                  sample_ff, sample_in;
   logic                  running_ff, running_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [CFG_BITS-1:0]   sel_cfg;
   logic [TIMER_BITS-1:0] len;
   logic [TIMER_BITS-1:0] dec;
   logic                  stop;

   assign stop = jack_evt.inserted || jack_evt.removed;
   assign sel_cfg = button_level ? cfg.release_settle :
                    in_call      ? cfg.press_settle_call : cfg.press_settle;
   assign len = TIMER_BITS'(timer_length(sel_cfg, TIMER_BITS));

   always_comb begin
      // effect of the jack side first
      ignore_in  = jack_evt.inserted   ? !button_level :
                   jack_evt.set_ignore ? 1'b1 : ignore_ff;
      held_in    = jack_evt.removed ? 1'b0 : held_ff;
      released   = jack_evt.removed && held_ff;
      pressed    = 1'b0;
      sample_in  = jack_evt.inserted ? button_level : sample_ff;
      timer_in   = stop ? '0 : timer_ff;
      running_in = stop ? 1'b0 : running_ff;
      dec        = timer_in - TIMER_BITS'(timer_in != '0);

      if (jack_evt.present && !jack_evt.inserted) begin
         if (button_level != sample_in) begin
            sample_in  = button_level;
            timer_in   = len;
            running_in = 1'b1;
         end else if (running_in) begin
            timer_in = dec;
            if (dec == '0) begin
               running_in = 1'b0;
               if (!button_level) begin
                  if (!ignore_in && !held_in) begin
                     held_in = 1'b1;
                     pressed = 1'b1;
                  end
               end else if (ignore_in) begin
                  ignore_in = 1'b0;
               end else if (held_in) begin
                  held_in  = 1'b0;
                  released = 1'b1;
               end
            end
         end
      end
   end

   assign held = held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         ignore_ff  <= 1'b0;
         sample_ff  <= 1'b1;
         running_ff <= 1'b0;
         timer_ff   <= '0;
      end else if (step_en) begin
         held_ff    <= held_in;
         ignore_ff  <= ignore_in;
         sample_ff  <= sample_in;
         running_ff <= running_in;
         timer_ff   <= timer_in;
      end
   end

   // press and release never reported on one tick
   a_press_release: assert property (@(posedge clock) disable iff (reset)
      !(pressed && released))
      else $error("press and release on one tick");

   // with no headset the button cannot stay held
   a_held_needs_jack: assert property (@(posedge clock) disable iff (reset)
      held_in |-> jack_evt.present)
      else $error("button held without headset");

   // removal stops the button timer
   a_removal_stops: assert property (@(posedge clock) disable iff (reset)
      step_en && jack_evt.removed |=> !running_ff)
      else $error("button timer running after removal");

endmodule

FILE: rtl/headset_jack_button_qualifier_unit.sv
// headset jack and button qualifier top level: input register, qualifiers, result register
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   jack_level, button_level, in_call
//   rsp      out        rsp_valid/rsp_ready   presence, held, four event pulses
//   csr      in         apb-style, pready=1   five 16-bit settle lengths
//
// one tick per cycle while the result is not stalled: a transaction is held in the
// input register and the qualifiers update their state on the way to the result
// register, where the result becomes valid. a stalled result holds the input register,
// and a new transaction is taken only while the input register is empty or moving on.
// synchronous reset clears all qualifier state and loads the default lengths.
module headset_jack_button_qualifier_unit #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_jack_level,
   input  logic                                req_button_level,
   input  logic                                req_in_call,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_headset_present,
   output logic                                rsp_button_held,
   output logic                                rsp_inserted,
   output logic                                rsp_removed,
   output logic                                rsp_pressed,
   output logic                                rsp_released,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hjbq_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hjbq_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hjbq_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import hjbq_pkg::*;

   cfg_type      cfg;
   jack_evt_type jack_evt;
   logic         in_valid_ff;
   logic         jack_ff, button_ff, call_ff;
   logic         out_valid_ff;
   logic         present_ff, held_ff, ins_ff, rem_ff, prs_ff, rel_ff;
   logic         step_en;
   logic         held, pressed, released;

   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   hjbq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hjbq_jack #(.TIMER_BITS(TIMER_BITS)) u_jack (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .jack_level (jack_ff),
      .cfg        (cfg),
      .jack_evt   (jack_evt)
   );

   hjbq_button #(.TIMER_BITS(TIMER_BITS)) u_button (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .button_level (button_ff),
      .in_call      (call_ff),
      .cfg          (cfg),
      .jack_evt     (jack_evt),
      .held         (held),
      .pressed      (pressed),
      .released     (released)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step_en) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         jack_ff   <= req_jack_level;
         button_ff <= req_button_level;
         call_ff   <= req_in_call;
      end
      if (step_en) begin
         present_ff <= jack_evt.present;
         held_ff    <= held;
         ins_ff     <= jack_evt.inserted;
         rem_ff     <= jack_evt.removed;
         prs_ff     <= pressed;
         rel_ff     <= released;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_headset_present = present_ff;
   assign rsp_button_held     = held_ff;
   assign rsp_inserted        = ins_ff;
   assign rsp_removed         = rem_ff;
   assign rsp_pressed         = prs_ff;
   assign rsp_released        = rel_ff;

   // an insertion result always shows the headset present
   a_ins_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> rsp_headset_present)
      else $error("insertion without presence");

   // a removal result shows nothing present and nothing held
   a_rem_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed |-> !rsp_headset_present && !rsp_button_held)
      else $error("removal leaves state behind");

   // a press result shows the button held
   a_prs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressed |-> rsp_button_held)
      else $error("press without held button");

endmodule
